[hdl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FRD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("frd assertion failed");
`define FRD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frd implication failed");
`else
`define FRD_ASSERT(lbl, clk, rst_n, prop)
`define FRD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`endif
`endif

[hdl/frd_pkg.sv]
// ---------------------------------------------------------------------------
// Frame deframer package
// Shared types, codes, constants and CRC helper of the frame deframer.
// ---------------------------------------------------------------------------
package frd_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam logic [15:0] MAX_PAYLOAD = 16'd512;

  localparam logic [15:0] MAX_LEN_RST = 16'd512;
  localparam logic [15:0] TIMEOUT_RST = 16'd400;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  localparam logic [7:0] BYTE_DROP    = 8'hF0;
  localparam logic [7:0] LEGACY_LO    = 8'h41;
  localparam logic [7:0] LEGACY_HI    = 8'h7A;
  localparam logic [7:0] LEGACY_QUERY = 8'h3F;

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'd1;

  typedef enum logic [2:0] {
    KIND_PAYLOAD = 3'd0,
    KIND_GOOD    = 3'd1,
    KIND_CRCBAD  = 3'd2,
    KIND_BADLEN  = 3'd3,
    KIND_TIMEOUT = 3'd4,
    KIND_LEGACY  = 3'd5
  } frd_kind_e;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
    logic       is_drop;
    logic       is_legacy;
  } frd_entry_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'h0);
    end
    return c;
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

endpackage

[hdl/frd_if.sv]
// ---------------------------------------------------------------------------
// Frame deframer channels
// Input, result and register write channels with valid/ready handshake.
// ---------------------------------------------------------------------------
interface frd_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] rx_byte;
  modport source (output valid, output action, output rx_byte, input ready);
  modport sink (input valid, input action, input rx_byte, output ready);
endinterface

interface frd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  data_byte;
  logic [15:0] frame_length;
  logic [15:0] error_total;
  logic [15:0] command_total;
  modport source (output valid, output kind, output data_byte, output frame_length,
                  output error_total, output command_total, input ready);
  modport sink (input valid, input kind, input data_byte, input frame_length,
                input error_total, input command_total, output ready);
endinterface

interface frd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [frd_pkg::CFG_IDX_W-1:0]  index;
  logic [15:0]                    data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[hdl/frd_front.sv]
// ---------------------------------------------------------------------------
// Frame deframer front end
// Accepts input transfers and tags each byte class before queueing.
// ---------------------------------------------------------------------------
module frd_front (
  frd_in_if.sink             in_i,
  input  logic               q_full_i,
  output logic               push_o,
  output frd_pkg::frd_entry_t entry_o
);

  logic [7:0] b;

  assign b         = in_i.rx_byte;
  assign in_i.ready = !q_full_i;
  assign push_o    = in_i.valid && !q_full_i;

  always_comb begin
    entry_o.action    = in_i.action;
    entry_o.rx_byte   = b;
    entry_o.is_drop   = (b == frd_pkg::BYTE_DROP);
    entry_o.is_legacy = ((b >= frd_pkg::LEGACY_LO) && (b <= frd_pkg::LEGACY_HI)) ||
                        (b == frd_pkg::LEGACY_QUERY);
  end

endmodule

[hdl/frd_queue.sv]
// ---------------------------------------------------------------------------
// Frame deframer queue
// Small FIFO between front end and back end.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module frd_queue #(
  parameter int unsigned DEPTH = frd_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  frd_pkg::frd_entry_t entry_i,
  output logic                full_o,
  output logic                valid_o,
  output frd_pkg::frd_entry_t head_o,
  input  logic                pop_i
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  frd_pkg::frd_entry_t mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_FULL);
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  `FRD_ASSERT_IMP(a_no_push_full, clk_i, rst_ni, full_o, !push_i)
  `FRD_ASSERT_IMP(a_no_pop_empty, clk_i, rst_ni, !valid_o, !pop_i)
  `FRD_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CNT_FULL)

endmodule

[hdl/frd_back.sv]
// ---------------------------------------------------------------------------
// Frame deframer back end
// Frame parser, CRC-32 check, counters, registers and result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module frd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  frd_pkg::frd_entry_t head_i,
  output logic                pop_o,
  frd_out_if.source           out_o,
  frd_cfg_if.sink             cfg_i
);

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_LENLO   = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;
  localparam logic [1:0] PH_CRC     = 2'd3;

  logic [15:0] max_len_q, timeout_q;
  logic [1:0]  phase_q, phase_d;
  logic [15:0] decl_q, decl_d;
  logic [15:0] cnt_q, cnt_d;
  logic [31:0] crc_q, crc_d;
  logic [31:0] rx_crc_q, rx_crc_d;
  logic [15:0] timer_q, timer_d;
  logic [15:0] err_q, err_d;
  logic [15:0] cmd_q, cmd_d;

  logic                has_res;
  frd_pkg::frd_kind_e  res_kind;
  logic [7:0]          res_data;
  logic [15:0]         res_len;

  logic                out_valid_q;
  logic [2:0]          out_kind_q;
  logic [7:0]          out_data_q;
  logic [15:0]         out_len_q, out_err_q, out_cmd_q;

  logic [15:0] limit, lenw, cnt_inc;
  logic [31:0] rx_crc_w;
  logic [7:0]  b;

  assign b        = head_i.rx_byte;
  assign limit    = (max_len_q > frd_pkg::MAX_PAYLOAD) ? frd_pkg::MAX_PAYLOAD : max_len_q;
  assign lenw     = {decl_q[15:8], b};
  assign cnt_inc  = cnt_q + 16'd1;
  assign rx_crc_w = {rx_crc_q[23:0], b};

  always_comb begin
    phase_d  = phase_q;
    decl_d   = decl_q;
    cnt_d    = cnt_q;
    crc_d    = crc_q;
    rx_crc_d = rx_crc_q;
    timer_d  = timer_q;
    err_d    = err_q;
    cmd_d    = cmd_q;
    has_res  = 1'b0;
    res_kind = frd_pkg::KIND_PAYLOAD;
    res_data = 8'h00;
    res_len  = 16'h0000;
    if (head_i.action) begin
      if (phase_q != PH_IDLE) begin
        if (timer_q < timeout_q) begin
          timer_d = timer_q + 16'd1;
        end else begin
          has_res  = 1'b1;
          res_kind = frd_pkg::KIND_TIMEOUT;
          res_len  = (phase_q == PH_LENLO) ? 16'h0000 : decl_q;
          phase_d  = PH_IDLE;
          timer_d  = '0;
        end
      end
    end else begin
      case (phase_q)
        PH_IDLE: begin
          cmd_d = frd_pkg::sat_inc(cmd_q);
          if (head_i.is_drop) begin
            phase_d = PH_IDLE;
          end else if (head_i.is_legacy) begin
            has_res  = 1'b1;
            res_kind = frd_pkg::KIND_LEGACY;
            res_data = b;
          end else begin
            decl_d  = {b, 8'h00};
            phase_d = PH_LENLO;
            timer_d = '0;
          end
        end
        PH_LENLO: begin
          decl_d = lenw;
          if ((lenw == 16'h0000) || (lenw > limit)) begin
            err_d    = frd_pkg::sat_inc(err_q);
            phase_d  = PH_IDLE;
            timer_d  = '0;
            has_res  = 1'b1;
            res_kind = frd_pkg::KIND_BADLEN;
            res_len  = lenw;
          end else begin
            phase_d = PH_PAYLOAD;
            cnt_d   = '0;
            crc_d   = frd_pkg::CRC_INIT;
            timer_d = '0;
          end
        end
        PH_PAYLOAD: begin
          crc_d    = frd_pkg::crc_byte(crc_q, b);
          cnt_d    = cnt_inc;
          has_res  = 1'b1;
          res_kind = frd_pkg::KIND_PAYLOAD;
          res_data = b;
          if (cnt_inc >= decl_q) begin
            phase_d  = PH_CRC;
            cnt_d    = '0;
            rx_crc_d = '0;
            timer_d  = '0;
          end
        end
        default: begin
          rx_crc_d = rx_crc_w;
          cnt_d    = cnt_inc;
          if (cnt_inc >= 16'd4) begin
            phase_d = PH_IDLE;
            cnt_d   = '0;
            timer_d = '0;
            has_res = 1'b1;
            res_len = decl_q;
            if (rx_crc_w == ~crc_q) begin
              res_kind = frd_pkg::KIND_GOOD;
            end else begin
              res_kind = frd_pkg::KIND_CRCBAD;
              err_d    = frd_pkg::sat_inc(err_q);
            end
          end
        end
      endcase
    end
  end

  assign pop_o = q_valid_i && (!has_res || !out_valid_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      decl_q   <= '0;
      cnt_q    <= '0;
      crc_q    <= frd_pkg::CRC_INIT;
      rx_crc_q <= '0;
      timer_q  <= '0;
      err_q    <= '0;
      cmd_q    <= '0;
    end else if (pop_o) begin
      phase_q  <= phase_d;
      decl_q   <= decl_d;
      cnt_q    <= cnt_d;
      crc_q    <= crc_d;
      rx_crc_q <= rx_crc_d;
      timer_q  <= timer_d;
      err_q    <= err_d;
      cmd_q    <= cmd_d;
    end
  end

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= frd_pkg::MAX_LEN_RST;
      timeout_q <= frd_pkg::TIMEOUT_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        frd_pkg::CFG_MAX_LEN: max_len_q <= cfg_i.data;
        frd_pkg::CFG_TIMEOUT: timeout_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o && has_res) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && has_res) begin
      out_kind_q <= res_kind;
      out_data_q <= res_data;
      out_len_q  <= res_len;
      out_err_q  <= err_d;
      out_cmd_q  <= cmd_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.kind          = out_kind_q;
  assign out_o.data_byte     = out_data_q;
  assign out_o.frame_length  = out_len_q;
  assign out_o.error_total   = out_err_q;
  assign out_o.command_total = out_cmd_q;

  `FRD_ASSERT_IMP(a_no_overwrite, clk_i, rst_ni, pop_o && has_res,
                  !out_valid_q || out_o.ready)
  `FRD_ASSERT_IMP(a_crc_cnt, clk_i, rst_ni, phase_q == PH_CRC, cnt_q < 16'd4)
  `FRD_ASSERT(a_err_mono, clk_i, rst_ni, err_q >= $past(err_q))

endmodule

[hdl/framed_request_deframer_crc32_unit.sv]
// ---------------------------------------------------------------------------
// Framed request deframer with CRC-32 check
// Parses length-prefixed frames from a byte stream with timer ticks.
// ---------------------------------------------------------------------------
// in_i carries one event per transfer: a received byte (action 0) or a timer
// tick (action 1). out_o carries at most one result per event: payload byte,
// frame good, CRC mismatch, bad length, timeout or legacy command byte, with
// the saturating error and command totals after that event.
// cfg_i writes max_payload_len (index 0) and timeout_ticks (index 1); it is
// always ready. The user must write it only while the block is idle; the
// block itself does not enforce this. Throughput: one event per cycle, set
// by the back end parser, which retires one queue entry per cycle with the
// CRC byte update done combinationally, except that an event with a result
// waits while a stalled receiver holds the result register. A result passes
// through a queue entry and then the result register before it is valid.
// Reset clears the parser to idle, CRC to all ones, counters to zero and the
// registers to 512 and 400. A stalled receiver holds the result register;
// the back end keeps retiring events that give no result, and the queue of
// QUEUE_DEPTH entries fills before in_i.ready drops.
// ---------------------------------------------------------------------------
module framed_request_deframer_crc32_unit #(
  parameter int unsigned QUEUE_DEPTH = frd_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  frd_in_if.sink      in_i,
  frd_out_if.source   out_o,
  frd_cfg_if.sink     cfg_i
);

  logic                q_full, q_valid, push, pop;
  frd_pkg::frd_entry_t entry, head;

  frd_front u_front (
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (push),
    .entry_o  (entry)
  );

  frd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .full_o  (q_full),
    .valid_o (q_valid),
    .head_o  (head),
    .pop_i   (pop)
  );

  frd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .head_i    (head),
    .pop_o     (pop),
    .out_o     (out_o),
    .cfg_i     (cfg_i)
  );

endmodule
